// ----- hw/rtl/char_lcd_text_cursor_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// Character LCD sequencer: assertion macros
// Simulation-only property checks; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_TEXT_CURSOR_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_TEXT_CURSOR_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LCDSEQ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// antecedent implies consequent in the next cycle
`define LCDSEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define LCDSEQ_ASSERT(lbl, clk, rst_n, ante, cons)
`define LCDSEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lcdseq_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD sequencer package
// Shared types, codes and the row start address table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

    // default depth of the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // action codes
    localparam logic [1:0] ACT_PRINT = 2'd0;
    localparam logic [1:0] ACT_PLACE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // LCD command and character codes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    // cursor count of a full screen
    localparam logic [6:0] SCREEN_LEN = 7'd64;
    localparam logic [1:0] LAST_ROW   = 2'd3;

    // input transaction
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
        logic [1:0] row;
        logic [3:0] column;
    } t_in_item;

    // output transaction (one bus write)
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_value;
        logic       last;
    } t_out_item;

    // one decoded action: up to three bytes, sent in slot order
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0]      is_data;
        logic [2:0][7:0] bytes;
    } t_job;

    // DDRAM set-address command for the start of a row
    function automatic logic [7:0] row_start(input logic [1:0] row);
        logic [7:0] addr;
        unique case (row)
            2'd0: addr = 8'h80;
            2'd1: addr = 8'hC0;
            2'd2: addr = 8'h90;
            2'd3: addr = 8'hD0;
        endcase
        return addr;
    endfunction

endpackage

// ----- hw/rtl/lcdseq_front.sv -----
// ----------------------------------------------------------------------------
// Character LCD sequencer: front end
// Accepts actions, tracks the cursor count and decodes each action into a
// job of up to three bytes for the queue.
// ----------------------------------------------------------------------------
module lcdseq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  lcdseq_pkg::t_in_item  i_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output lcdseq_pkg::t_job      o_job
);

    logic [6:0] r_cursor;
    logic [6:0] n_cursor;
    logic [1:0] nb;
    logic       clr;
    logic [1:0] cur_row;
    logic       accept;

    // decode one action into bytes and the next cursor count
    always_comb begin
        o_job    = '0;
        nb       = 2'd0;
        n_cursor = r_cursor;
        clr      = (r_cursor == lcdseq_pkg::SCREEN_LEN);
        cur_row  = r_cursor[5:4];
        unique case (i_data.action)
            lcdseq_pkg::ACT_PRINT: begin
                // row start: clear on a full screen, then address the row
                if (r_cursor[3:0] == 4'd0) begin
                    if (clr) begin
                        o_job.bytes[nb]   = lcdseq_pkg::CMD_CLEAR;
                        o_job.is_data[nb] = 1'b0;
                        nb                = nb + 2'd1;
                    end
                    o_job.bytes[nb]   = lcdseq_pkg::row_start(cur_row);
                    o_job.is_data[nb] = 1'b0;
                    nb                = nb + 2'd1;
                end
                if (i_data.character == lcdseq_pkg::NEWLINE_CODE) begin
                    if (cur_row == lcdseq_pkg::LAST_ROW) begin
                        n_cursor = lcdseq_pkg::SCREEN_LEN;
                    end else begin
                        o_job.bytes[nb]   = lcdseq_pkg::row_start(cur_row + 2'd1);
                        o_job.is_data[nb] = 1'b0;
                        nb                = nb + 2'd1;
                        n_cursor          = {1'b0, cur_row + 2'd1, 4'd0};
                    end
                end else begin
                    o_job.bytes[nb]   = i_data.character;
                    o_job.is_data[nb] = 1'b1;
                    nb                = nb + 2'd1;
                    n_cursor          = clr ? 7'd1 : (r_cursor + 7'd1);
                end
            end
            lcdseq_pkg::ACT_PLACE: begin
                o_job.bytes[0]   = lcdseq_pkg::row_start(i_data.row)
                                 + {4'd0, i_data.column};
                o_job.is_data[0] = 1'b0;
                o_job.bytes[1]   = i_data.character;
                o_job.is_data[1] = 1'b1;
                nb               = 2'd2;
                n_cursor         = {1'b0, i_data.row, i_data.column} + 7'd1;
            end
            lcdseq_pkg::ACT_CLEAR: begin
                o_job.bytes[0]   = lcdseq_pkg::CMD_CLEAR;
                o_job.is_data[0] = 1'b0;
                nb               = 2'd1;
                n_cursor         = 7'd0;
            end
            default: begin
                // unused code: no writes, cursor unchanged
                nb = 2'd0;
            end
        endcase
        o_job.count = nb;
    end

    // handshake: a transaction with no writes is taken and dropped
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (nb != 2'd0);

    // cursor count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= 7'd0;
        end else if (accept) begin
            r_cursor <= n_cursor;
        end
    end

endmodule

// ----- hw/rtl/lcdseq_fifo.sv -----
// ----------------------------------------------------------------------------
// Character LCD sequencer: job queue
// Small register queue that decouples the decoder from the bus writer.
// ----------------------------------------------------------------------------
module lcdseq_fifo #(
    parameter int unsigned DEPTH = lcdseq_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcdseq_pkg::t_job  i_job,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output lcdseq_pkg::t_job  o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lcdseq_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/lcdseq_back.sv -----
// ----------------------------------------------------------------------------
// Character LCD sequencer: bus writer
// Walks the bytes of the head job, splits them into nibbles on a 4-bit
// bus, and drives the output register one write per cycle while i_ready allows.
// ----------------------------------------------------------------------------
module lcdseq_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_bus_width_4,
    input  logic                   i_q_valid,
    input  lcdseq_pkg::t_job       i_q_job,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lcdseq_pkg::t_out_item  o_data
);

    logic [1:0]            r_idx;
    logic                  r_nib;
    logic                  r_valid;
    lcdseq_pkg::t_out_item r_data;
    logic                  load;
    logic [7:0]            cur_byte;
    logic                  byte_done;
    logic                  job_done;
    lcdseq_pkg::t_out_item n_data;

    // next write from the head job
    always_comb begin
        load      = i_q_valid && (!r_valid || i_ready);
        cur_byte  = i_q_job.bytes[r_idx];
        byte_done = !i_bus_width_4 || r_nib;
        job_done  = byte_done && (r_idx == (i_q_job.count - 2'd1));
        n_data.is_data = i_q_job.is_data[r_idx];
        if (i_bus_width_4) begin
            n_data.bus_value = r_nib ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
        end else begin
            n_data.bus_value = cur_byte;
        end
        n_data.last = job_done;
    end

    assign o_q_pop = load && job_done;

    // byte and nibble position within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_nib <= 1'b0;
        end else if (load) begin
            if (byte_done) begin
                r_nib <= 1'b0;
                r_idx <= job_done ? 2'd0 : (r_idx + 2'd1);
            end else begin
                r_nib <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/char_lcd_text_cursor_sequencer.sv -----
// ----------------------------------------------------------------------------
// Character LCD text and cursor sequencer (top level)
// Turns print, place and clear actions into LCD command/data bus writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready/i_data) takes one action per transaction.
//   Output channel (o_valid/i_ready/o_data) gives one bus write per
//   transaction; last marks the final write of an action. An action makes
//   0 to 3 bytes, each one write on an 8-bit bus or two (high nibble
//   first) on a 4-bit bus, so 0 to 6 writes.
//   Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) sets the 4-bit bus
//   mode; it is always ready and should only be written while idle.
//   Path: an accepted action is stored in the job queue, and its first write
//   is then loaded from the head job into the output register.
//   Throughput: the decoder takes one action per cycle while the job queue
//   has room; the bus writer emits one write per cycle while i_ready is
//   high, so sustained rate is set by the writes per action.
//   Stall: when i_ready is low the output register holds, the queue fills
//   and o_ready drops once it is full.
//   Reset: cursor count 0, 8-bit bus, queue and output empty.
// ----------------------------------------------------------------------------
`include "char_lcd_text_cursor_sequencer_defines.svh"

module char_lcd_text_cursor_sequencer #(
    parameter int unsigned QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // action input
    input  logic                   i_valid,
    output logic                   o_ready,
    input  lcdseq_pkg::t_in_item   i_data,
    // bus write output
    output logic                   o_valid,
    input  logic                   i_ready,
    output lcdseq_pkg::t_out_item  o_data,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);

    logic             r_bus_width_4;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    lcdseq_pkg::t_job front_job;
    lcdseq_pkg::t_job head_job;

    // bus width register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_width_4 <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bus_width_4 <= i_cfg_data;
        end
    end

    // decoder
    lcdseq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    // job queue
    lcdseq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    // bus writer
    lcdseq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bus_width_4 (r_bus_width_4),
        .i_q_valid     (q_valid),
        .i_q_job       (head_job),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

    // checks
    `LCDSEQ_ASSERT(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    `LCDSEQ_ASSERT(a_nibble_range, i_clk, i_rst_n, o_valid && r_bus_width_4, o_data.bus_value[7:4] == 4'd0)
    `LCDSEQ_ASSERT(a_data_is_last, i_clk, i_rst_n, o_valid && !r_bus_width_4 && o_data.is_data, o_data.last)
    `LCDSEQ_ASSERT_NEXT(a_idle_drains, i_clk, i_rst_n, !q_valid && (!o_valid || i_ready), !o_valid)

endmodule

// ----- tb/char_lcd_text_cursor_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD sequencer testbench
// Drives print, place and clear actions into the sequencer and checks every
// LCD bus write against an in-bench model of the cursor count and bus mode.
// Covers both bus widths, random stalls on either side and a long output
// stall that backs up the action input.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_sequencer_tb;

    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         SETTLE_CYC   = 8;
    localparam int         LONG_STALL   = 60;
    localparam int         SEG_ACTIONS  = 68;
    localparam longint     TIMEOUT_NS   = 5_000_000;
    localparam logic [7:0] ROW_ADDR [4] = '{8'h80, 8'hC0, 8'h90, 8'hD0};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    lcdseq_pkg::t_in_item  i_data      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    lcdseq_pkg::t_out_item o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_data  = 1'b0;

    char_lcd_text_cursor_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // actions waiting to be offered, bus writes still owed by the block
    lcdseq_pkg::t_in_item  action_q[$];
    lcdseq_pkg::t_out_item exp_writes[$];
    lcdseq_pkg::t_out_item step_writes[$];

    // mirror of the block's state
    logic [6:0] model_cursor      = '0;
    logic       model_nibble_mode = 1'b0;

    int   err_cnt      = 0;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   stall_req    = 0;
    int   stall_served = 0;
    int   rx_stall_left = 0;
    logic in_acc       = 1'b0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one byte becomes one write, or two nibble writes (high first)
    function automatic void put_byte(logic is_data, logic [7:0] b);
        lcdseq_pkg::t_out_item w;
        w.is_data = is_data;
        w.last    = 1'b0;
        if (model_nibble_mode) begin
            w.bus_value = {4'h0, b[7:4]};
            step_writes.push_back(w);
            w.bus_value = {4'h0, b[3:0]};
            step_writes.push_back(w);
        end else begin
            w.bus_value = b;
            step_writes.push_back(w);
        end
    endfunction

    // bus writes caused by one action; updates the cursor count
    function automatic void predict_bus_writes(lcdseq_pkg::t_in_item it);
        int next_row;
        lcdseq_pkg::t_out_item w;
        step_writes.delete();
        case (it.action)
            lcdseq_pkg::ACT_PRINT: begin
                if (model_cursor[3:0] == 4'd0) begin
                    // full screen: clear, then restart at the top row
                    if (model_cursor == lcdseq_pkg::SCREEN_LEN) begin
                        put_byte(1'b0, lcdseq_pkg::CMD_CLEAR);
                        model_cursor = '0;
                    end
                    put_byte(1'b0, ROW_ADDR[model_cursor[5:4]]);
                end
                if (it.character == lcdseq_pkg::NEWLINE_CODE) begin
                    next_row = int'(model_cursor[5:4]) + 1;
                    // newline on the last row only parks the cursor at the end
                    if (next_row >= 4) begin
                        model_cursor = lcdseq_pkg::SCREEN_LEN;
                    end else begin
                        put_byte(1'b0, ROW_ADDR[2'(next_row)]);
                        model_cursor = 7'(next_row * 16);
                    end
                end else begin
                    put_byte(1'b1, it.character);
                    model_cursor = model_cursor + 7'd1;
                end
            end
            lcdseq_pkg::ACT_PLACE: begin
                put_byte(1'b0, ROW_ADDR[it.row] + {4'h0, it.column});
                put_byte(1'b1, it.character);
                model_cursor = 7'(16 * int'(it.row) + int'(it.column) + 1);
            end
            lcdseq_pkg::ACT_CLEAR: begin
                put_byte(1'b0, lcdseq_pkg::CMD_CLEAR);
                model_cursor = '0;
            end
            default: begin
            end
        endcase
        if (step_writes.size() > 0) begin
            w = step_writes.pop_back();
            w.last = 1'b1;
            step_writes.push_back(w);
        end
        foreach (step_writes[k]) exp_writes.push_back(step_writes[k]);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // monitor: predict on accepted actions, check each accepted bus write
    always @(posedge i_clk) begin
        lcdseq_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_acc <= 1'b0;
        end else begin
            in_acc <= i_valid && o_ready;
            if (i_valid && o_ready) predict_bus_writes(i_data);
            if (o_valid && i_ready) begin
                if (exp_writes.size() == 0) begin
                    $error("bus write with nothing pending: is_data %0d value 0x%0h last %0d",
                           o_data.is_data, o_data.bus_value, o_data.last);
                    err_cnt++;
                end else begin
                    want = exp_writes.pop_front();
                    check_field("is_data", 8'(want.is_data), 8'(o_data.is_data));
                    check_field("bus_value", want.bus_value, o_data.bus_value);
                    check_field("last", 8'(want.last), 8'(o_data.last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) model_nibble_mode = i_cfg_data;
        end
    end

    // action driver: holds each transaction until taken, then maybe idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_acc) begin
            if (action_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= action_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // write receiver: random backpressure plus on-demand long stalls
    always @(negedge i_clk) begin
        if (stall_served != stall_req) begin
            stall_served  = stall_req;
            rx_stall_left = LONG_STALL;
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic queue_action(logic [1:0] act, logic [7:0] ch, logic [1:0] row,
                                logic [3:0] col);
        lcdseq_pkg::t_in_item it;
        it.action    = act;
        it.character = ch;
        it.row       = row;
        it.column    = col;
        action_q.push_back(it);
    endtask

    // mostly prints with frequent newlines so the cursor walks the screen
    function automatic lcdseq_pkg::t_in_item rand_action();
        lcdseq_pkg::t_in_item it;
        int pick;
        it.character = 8'($urandom_range(255));
        it.row       = 2'($urandom_range(3));
        it.column    = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 64) begin
            it.action = lcdseq_pkg::ACT_PRINT;
            if ($urandom_range(99) < 12) it.character = lcdseq_pkg::NEWLINE_CODE;
        end else if (pick < 88) begin
            it.action = lcdseq_pkg::ACT_PLACE;
        end else if (pick < 95) begin
            it.action = lcdseq_pkg::ACT_CLEAR;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    // wait until every action is taken and every write has come back
    task automatic drain_all();
        @(posedge i_clk);
        while (action_q.size() != 0 || i_valid || exp_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_bus_mode(logic nibble_mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= nibble_mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(int profile);
        case (profile)
            0: begin tx_idle_pct = 24; rx_idle_pct = 79; end
            1: begin tx_idle_pct = 79; rx_idle_pct = 24; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    // stimulus
    initial begin
        int n_real;
        lcdseq_pkg::t_in_item it;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idle(0);
        write_bus_mode(1'b0);

        // directed: row starts, full screen clear, newline cases, all actions
        queue_action(lcdseq_pkg::ACT_PRINT, 8'h41, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PRINT, 8'h00, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, 8'hFF, 2'd3, 4'd15);
        queue_action(lcdseq_pkg::ACT_PRINT, 8'h42, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, 8'h55, 2'd3, 4'd14);
        queue_action(lcdseq_pkg::ACT_PRINT, 8'h7A, 2'd1, 4'd3);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, 8'h78, 2'd2, 4'd0);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd3, 4'd15);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, 8'h31, 2'd3, 4'd0);
        // newline mid last row: no writes at all
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd2, 4'd7);
        queue_action(ACT_UNUSED, 8'hC3, 2'd2, 4'd9);
        queue_action(lcdseq_pkg::ACT_PRINT, 8'h80, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_CLEAR, 8'h00, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PRINT, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, lcdseq_pkg::NEWLINE_CODE, 2'd0, 4'd0);
        queue_action(lcdseq_pkg::ACT_PLACE, 8'hAA, 2'd1, 4'd5);
        queue_action(lcdseq_pkg::ACT_CLEAR, 8'hFF, 2'd3, 4'd15);
        queue_action(lcdseq_pkg::ACT_PRINT, 8'hFF, 2'd3, 4'd15);

        // random segments: alternate bus width, step through idle profiles
        for (int seg = 0; seg < 6; seg++) begin
            drain_all();
            write_bus_mode(seg % 2 == 0);
            set_idle(seg / 2);
            n_real = 0;
            while (n_real < SEG_ACTIONS) begin
                it = rand_action();
                action_q.push_back(it);
                if (it.action != ACT_UNUSED) n_real++;
            end
            // long output stall while actions keep coming
            if (seg == 2 || seg == 4) stall_req++;
        end
        drain_all();

        if (err_cnt == 0 && exp_writes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
